FILE: rtl/isk_pkg.sv
`default_nettype none

package isk_pkg;

  localparam int          KEY_DEPTH     = 128;
  localparam int          KEY_AW        = 7;
  localparam logic [7:0]  SEP_CHAR      = 8'h5C;
  localparam logic [7:0]  OUT_LIMIT_RST = 8'd128;
  localparam logic [7:0]  KEY_LEN_MAX   = 8'd255;
  localparam logic [7:0]  KEY_DEPTH_B   = 8'd128;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              wr_en;
    logic [KEY_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [KEY_AW-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value_byte;
    logic       found;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/isk_if.sv
`default_nettype none

interface isk_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;

  modport source (output valid, output op, output byte_in, input ready);
  modport sink   (input valid, input op, input byte_in, output ready);
endinterface

interface isk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       found;
  logic       last;

  modport source (output valid, output value_byte, output found, output last, input ready);
  modport sink   (input valid, input value_byte, input found, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/isk_key_ram.sv
`default_nettype none

module isk_key_ram (
  input  wire logic              clk,
  input  wire isk_pkg::ram_req_t ram_req,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [isk_pkg::KEY_DEPTH];

  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_req.rd_en) begin
      rd_data <= mem[ram_req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/isk_ctrl.sv
`default_nettype none

module isk_ctrl #(
  parameter int FIELD_MAX = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              op,
  input  wire logic [7:0]        byte_in,
  input  wire logic [7:0]        out_limit,
  input  wire logic [7:0]        rd_data,
  output isk_pkg::ram_req_t      ram_req,
  output isk_pkg::result_t       result
);

  localparam int             FCW     = $clog2(FIELD_MAX);
  localparam logic [FCW-1:0] FC_FULL = FCW'(FIELD_MAX - 1);

  isk_pkg::phase_t phase_r, phase_nxt;
  logic [FCW-1:0]  fc_r, fc_nxt, fc_cur;
  logic [7:0]      fc_ext;
  logic            mm_r, mm_nxt, mm_fwd, mm_cur;
  logic            ans_r, ans_nxt;
  logic [7:0]      copy_r, copy_nxt;
  logic [7:0]      key_len_r, key_len_nxt, len_base;
  logic            key_done_r, key_done_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      pend_byte_r, pend_byte_nxt;
  logic            go_key, do_final;

  // The key byte read for the previous transaction arrives now; fold its compare in.
  assign mm_fwd = mm_r | (pend_r & (rd_data != pend_byte_r));
  assign fc_ext = 8'(fc_cur);

  always_comb begin
    phase_nxt     = phase_r;
    fc_nxt        = fc_r;
    mm_nxt        = mm_fwd;
    ans_nxt       = ans_r;
    copy_nxt      = copy_r;
    key_len_nxt   = key_len_r;
    key_done_nxt  = key_done_r;
    pend_nxt      = 1'b0;
    pend_byte_nxt = pend_byte_r;
    ram_req       = '0;
    result        = '0;
    fc_cur        = fc_r;
    mm_cur        = mm_fwd;
    go_key        = 1'b0;
    do_final      = 1'b0;
    len_base      = key_done_r ? 8'd0 : key_len_r;

    if (accept) begin
      if (!op) begin
        // Any key byte aborts a scan and starts the next one from the top.
        phase_nxt    = isk_pkg::PH_START;
        fc_nxt       = '0;
        mm_nxt       = 1'b0;
        ans_nxt      = 1'b0;
        copy_nxt     = 8'd0;
        key_done_nxt = 1'b0;
        key_len_nxt  = len_base;
        if (byte_in == 8'd0) begin
          key_done_nxt = 1'b1;
        end else begin
          if (len_base < isk_pkg::KEY_DEPTH_B) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = len_base[isk_pkg::KEY_AW-1:0];
            ram_req.wr_data = byte_in;
          end
          if (len_base != isk_pkg::KEY_LEN_MAX) begin
            key_len_nxt = len_base + 8'd1;
          end
        end
      end else begin
        unique case (phase_r)
          isk_pkg::PH_START: begin
            fc_cur    = '0;
            mm_cur    = 1'b0;
            fc_nxt    = '0;
            mm_nxt    = 1'b0;
            phase_nxt = isk_pkg::PH_KEY;
            go_key    = (byte_in != isk_pkg::SEP_CHAR);
          end
          isk_pkg::PH_KEY: begin
            go_key = 1'b1;
          end
          isk_pkg::PH_VALUE: begin
            if (byte_in == 8'd0) begin
              do_final = 1'b1;
            end else if (byte_in == isk_pkg::SEP_CHAR || fc_r >= FC_FULL) begin
              if (ans_r) begin
                phase_nxt = isk_pkg::PH_SKIP;
              end else begin
                phase_nxt = isk_pkg::PH_KEY;
                fc_nxt    = '0;
                mm_nxt    = 1'b0;
              end
            end else begin
              fc_nxt = fc_r + FCW'(1);
              if (ans_r && ({1'b0, copy_r} + 9'd1 < {1'b0, out_limit})) begin
                copy_nxt          = copy_r + 8'd1;
                result.valid      = 1'b1;
                result.value_byte = byte_in;
              end
            end
          end
          isk_pkg::PH_SKIP: begin
            do_final = (byte_in == 8'd0);
          end
          default: begin
            phase_nxt = isk_pkg::PH_START;
          end
        endcase

        if (go_key) begin
          if (byte_in == 8'd0) begin
            do_final = 1'b1;
          end else if (byte_in == isk_pkg::SEP_CHAR || fc_cur >= FC_FULL) begin
            if (key_done_r && !mm_cur && key_len_r <= isk_pkg::KEY_DEPTH_B &&
                fc_ext == key_len_r) begin
              ans_nxt = 1'b1;
            end
            mm_nxt    = mm_cur;
            phase_nxt = isk_pkg::PH_VALUE;
            fc_nxt    = '0;
          end else begin
            mm_nxt = mm_cur;
            if (fc_ext >= key_len_r || fc_ext >= isk_pkg::KEY_DEPTH_B) begin
              mm_nxt = 1'b1;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = fc_ext[isk_pkg::KEY_AW-1:0];
              pend_nxt        = 1'b1;
              pend_byte_nxt   = byte_in;
            end
            fc_nxt = fc_cur + FCW'(1);
          end
        end

        if (do_final) begin
          result.valid = 1'b1;
          result.found = ans_r;
          result.last  = 1'b1;
          phase_nxt    = isk_pkg::PH_START;
          fc_nxt       = '0;
          mm_nxt       = 1'b0;
          ans_nxt      = 1'b0;
          copy_nxt     = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= isk_pkg::PH_START;
      fc_r       <= '0;
      mm_r       <= 1'b0;
      ans_r      <= 1'b0;
      copy_r     <= 8'd0;
      key_len_r  <= 8'd0;
      key_done_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      fc_r       <= fc_nxt;
      mm_r       <= mm_nxt;
      ans_r      <= ans_nxt;
      copy_r     <= copy_nxt;
      key_len_r  <= key_len_nxt;
      key_done_r <= key_done_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/info_string_key_lookup.sv
`default_nettype none

// Channel    Direction  Payload                       Handshake
// in_chan    in         op[0], byte_in[7:0]           valid / ready
// out_chan   out        value_byte[7:0], found, last  valid / ready
// cfg        in         cfg_wr_data[7:0] (out_limit)  cfg_wr_en, no wait
//
// One transaction per cycle is taken while in_chan.ready is high; a scan byte issues
// at most one key RAM read, and the compare against the returned byte is folded into
// the mismatch flag in the following cycle, forwarded to any transaction arriving then.
// Each transaction yields at most one result, held in an output register.
// in_chan.ready is low only while that register is full and out_chan is stalled.
// Synchronous active-low reset clears control state; key RAM contents are not cleared.

module info_string_key_lookup #(
  parameter int FIELD_MAX = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  isk_in_if.sink          in_chan,
  isk_out_if.source       out_chan,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic              accept;
  logic [7:0]        out_limit_r;
  logic [7:0]        rd_data;
  isk_pkg::ram_req_t ram_req;
  isk_pkg::result_t  result;
  logic              out_valid_r;
  logic [7:0]        value_byte_r;
  logic              found_r;
  logic              last_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= isk_pkg::OUT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      out_limit_r <= cfg_wr_data;
    end
  end

  isk_ctrl #(
    .FIELD_MAX (FIELD_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_chan.op),
    .byte_in   (in_chan.byte_in),
    .out_limit (out_limit_r),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .result    (result)
  );

  isk_key_ram u_key_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      value_byte_r <= result.value_byte;
      found_r      <= result.found;
      last_r       <= result.last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value_byte = value_byte_r;
  assign out_chan.found      = found_r;
  assign out_chan.last       = last_r;

`ifndef SYNTH
  a_rd_on_scan : assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.rd_en |-> (accept && in_chan.op))
    else $error("key RAM read without an accepted scan transaction");

  a_wr_on_key : assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (accept && !in_chan.op && in_chan.byte_in != 8'd0))
    else $error("key RAM write without an accepted key character");

  a_res_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> (accept && in_chan.op))
    else $error("result produced without an accepted scan transaction");

  a_value_not_found : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> !out_chan.found)
    else $error("value byte result carries the found flag");
`endif

endmodule

`default_nettype wire
